// ----- hw/rtl/bmio_pkg.sv -----
`default_nettype none
package bmio_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int BUS_W         = 16;
  localparam int DATA_W        = 8;
  localparam int TYPE_W        = 3;
  localparam int PERIOD_W      = 16;

  localparam logic [BUS_W-1:0] HOLE_MASK  = 16'hFFF0;
  localparam logic [BUS_W-1:0] HOLE_BASE  = 16'hFFD0;
  localparam logic [BUS_W-1:0] REG_STATUS = 16'hFFD0;
  localparam logic [BUS_W-1:0] REG_DATA   = 16'hFFD1;
  localparam logic [BUS_W-1:0] REG_TIMER  = 16'hFFDD;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd23039;

  localparam int TIMER_CLEAR_BIT  = 7;
  localparam int TIMER_ENABLE_BIT = 1;
  localparam int STATUS_TXE_BIT   = 1;
  localparam int STATUS_RXF_BIT   = 0;

  typedef enum logic [TYPE_W-1:0] {
    REQ_READ     = 3'd0,
    REQ_WRITE    = 3'd1,
    REQ_RX       = 3'd2,
    REQ_TX_TAKEN = 3'd3,
    REQ_TICK     = 3'd4
  } bmio_req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } bmio_state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic commit;
  } bmio_cmd_t;

  typedef struct packed {
    logic clr_last;
  } bmio_sts_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_active;
    logic              tx_pending;
    logic [DATA_W-1:0] tx_byte;
    logic              rx_full;
    logic              host_accepted;
  } bmio_res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bmio_if.sv -----
`default_nettype none
interface bmio_in_if;
  import bmio_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [BUS_W-1:0]  bus_address;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output req_type, output bus_address, output data_in,
                  input ready);
  modport sink (input valid, input req_type, input bus_address, input data_in,
                output ready);
endinterface

interface bmio_out_if;
  import bmio_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_active;
  logic              tx_pending;
  logic [DATA_W-1:0] tx_byte;
  logic              rx_full;
  logic              host_accepted;

  modport source (output valid, output read_data, output irq_active, output tx_pending,
                  output tx_byte, output rx_full, output host_accepted, input ready);
  modport sink (input valid, input read_data, input irq_active, input tx_pending,
                input tx_byte, input rx_full, input host_accepted, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bmio_ram.sv -----
`default_nettype none
module bmio_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bmio_ctrl.sv -----
`default_nettype none
module bmio_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire bmio_pkg::bmio_sts_t sts,
  output bmio_pkg::bmio_cmd_t      cmd
);
  import bmio_pkg::*;

  bmio_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    out_valid_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- hw/rtl/bmio_dp.sv -----
`default_nettype none
module bmio_dp #(
  parameter int ADDR_BITS = bmio_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bmio_pkg::bmio_cmd_t             cmd,
  output bmio_pkg::bmio_sts_t                  sts,
  input  wire logic [bmio_pkg::TYPE_W-1:0]     in_req_type,
  input  wire logic [bmio_pkg::BUS_W-1:0]      in_bus_address,
  input  wire logic [bmio_pkg::DATA_W-1:0]     in_data_in,
  input  wire logic                            cfg_we,
  input  wire logic [bmio_pkg::PERIOD_W-1:0]   cfg_wdata,
  output bmio_pkg::bmio_res_t                  res
);
  import bmio_pkg::*;

  localparam int RAM_DEPTH = 1 << ADDR_BITS;

  logic                 ram_we, ram_re;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [DATA_W-1:0]    ram_wdata, ram_rdata;
  logic [ADDR_BITS-1:0] clr_addr_r;
  logic                 in_hole;

  bmio_req_t         req_r;
  logic [BUS_W-1:0]  addr_r;
  logic [DATA_W-1:0] data_r;

  logic                tx_empty_r, tx_empty_nxt;
  logic [DATA_W-1:0]   tx_holding_r, tx_holding_nxt;
  logic [DATA_W-1:0]   rx_holding_r, rx_holding_nxt;
  logic                rx_has_r, rx_has_nxt;
  logic                timer_on_r, timer_on_nxt;
  logic [PERIOD_W-1:0] timer_count_r, timer_count_nxt;
  logic                irq_r, irq_nxt;
  logic [PERIOD_W-1:0] period_r;
  bmio_res_t           res_r, res_nxt;
  logic                hole_r;
  logic [DATA_W-1:0]   rd;
  logic                accepted;

  assign in_hole = (in_bus_address & HOLE_MASK) == HOLE_BASE;
  assign hole_r  = (addr_r & HOLE_MASK) == HOLE_BASE;

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = in_bus_address[ADDR_BITS-1:0];
    ram_wdata = in_data_in;
    if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr_r;
      ram_wdata = '0;
    end else if (cmd.capture) begin
      ram_we = (in_req_type == REQ_WRITE) && !in_hole;
      ram_re = (in_req_type == REQ_READ) && !in_hole;
    end
  end

  bmio_ram #(
    .WIDTH(DATA_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign sts.clr_last = &clr_addr_r;

  always_comb begin
    tx_empty_nxt    = tx_empty_r;
    tx_holding_nxt  = tx_holding_r;
    rx_holding_nxt  = rx_holding_r;
    rx_has_nxt      = rx_has_r;
    timer_on_nxt    = timer_on_r;
    timer_count_nxt = timer_count_r;
    irq_nxt         = irq_r;
    rd              = '0;
    accepted        = 1'b0;
    unique case (req_r)
      REQ_READ: begin
        if (!hole_r) begin
          rd = ram_rdata;
        end else if (addr_r == REG_STATUS) begin
          rd[STATUS_TXE_BIT] = tx_empty_r;
          rd[STATUS_RXF_BIT] = rx_has_r;
        end else if (addr_r == REG_DATA) begin
          rd         = rx_holding_r;
          rx_has_nxt = 1'b0;
        end else if (addr_r == REG_TIMER) begin
          rd[TIMER_ENABLE_BIT] = timer_on_r;
          rd[TIMER_CLEAR_BIT]  = irq_r;
        end
      end
      REQ_WRITE: begin
        if (hole_r && addr_r == REG_DATA) begin
          tx_holding_nxt = data_r;
          tx_empty_nxt   = 1'b0;
        end else if (hole_r && addr_r == REG_TIMER) begin
          timer_on_nxt = data_r[TIMER_ENABLE_BIT];
          if (data_r[TIMER_CLEAR_BIT]) begin
            irq_nxt = 1'b0;
          end
        end
      end
      REQ_RX: begin
        if (!rx_has_r) begin
          rx_holding_nxt = data_r;
          rx_has_nxt     = 1'b1;
          accepted       = 1'b1;
        end
      end
      REQ_TX_TAKEN: begin
        tx_empty_nxt = 1'b1;
      end
      REQ_TICK: begin
        if (timer_on_r) begin
          if (timer_count_r >= period_r) begin
            timer_count_nxt = '0;
            irq_nxt         = 1'b1;
          end else begin
            timer_count_nxt = timer_count_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res_nxt.read_data     = rd;
    res_nxt.irq_active    = irq_nxt;
    res_nxt.tx_pending    = !tx_empty_nxt;
    res_nxt.tx_byte       = tx_holding_nxt;
    res_nxt.rx_full       = rx_has_nxt;
    res_nxt.host_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r    <= '0;
      tx_empty_r    <= 1'b1;
      tx_holding_r  <= '0;
      rx_holding_r  <= '0;
      rx_has_r      <= 1'b0;
      timer_on_r    <= 1'b0;
      timer_count_r <= '0;
      irq_r         <= 1'b0;
      period_r      <= PERIOD_RESET;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        tx_empty_r    <= tx_empty_nxt;
        tx_holding_r  <= tx_holding_nxt;
        rx_holding_r  <= rx_holding_nxt;
        rx_has_r      <= rx_has_nxt;
        timer_on_r    <= timer_on_nxt;
        timer_count_r <= timer_count_nxt;
        irq_r         <= irq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= bmio_req_t'(in_req_type);
      addr_r <= in_bus_address;
      data_r <= in_data_in;
    end
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ----- hw/rtl/bus_memory_and_io_responder.sv -----
`default_nettype none
// Bus responder for an 8-bit processor: RAM of 2^ADDR_BITS bytes everywhere outside
// $FFD0-$FFDF, plus a 6850-style serial port ($FFD0 status, $FFD1 data) and a periodic
// timer register ($FFDD) inside that window. After reset the RAM is zeroed one byte per
// cycle, so no request is taken until every byte has been cleared; cfg writes are taken
// throughout. Each request is then handled in turn: IDLE accepts it and launches the
// registered RAM access, then EXEC executes it and loads the result register once the
// output is free, and only then is the next request accepted. A result waiting in the
// output register does not stop the next request from being accepted.
module bus_memory_and_io_responder #(
  parameter int ADDR_BITS = bmio_pkg::ADDR_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bmio_in_if.sink                            in_ch,
  bmio_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [bmio_pkg::PERIOD_W-1:0] cfg_wdata
);
  import bmio_pkg::*;

  bmio_cmd_t cmd;
  bmio_sts_t sts;
  bmio_res_t res;

  bmio_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmio_dp #(
    .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_ch.req_type),
    .in_bus_address(in_ch.bus_address),
    .in_data_in    (in_ch.data_in),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .res           (res)
  );

  assign out_ch.read_data     = res.read_data;
  assign out_ch.irq_active    = res.irq_active;
  assign out_ch.tx_pending    = res.tx_pending;
  assign out_ch.tx_byte       = res.tx_byte;
  assign out_ch.rx_full       = res.rx_full;
  assign out_ch.host_accepted = res.host_accepted;

endmodule
`default_nettype wire

// ----- dv/bmio_response_checker.sv -----
`timescale 1ns / 1ps
module bmio_response_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  bmio_in_if                            in_ch,
  bmio_out_if                           out_ch,
  input  logic                          cfg_we,
  input  logic [bmio_pkg::PERIOD_W-1:0] cfg_wdata,
  output int                            fail_count,
  output int                            open_count,
  output int                            checked_count
);
  import bmio_pkg::*;

  localparam int MEM_DEPTH = 1 << ADDR_BITS_DEF;

  logic [DATA_W-1:0]   mem_image [MEM_DEPTH];
  logic                txe;
  logic [DATA_W-1:0]   tx_hold;
  logic [DATA_W-1:0]   rx_hold;
  logic                rxf;
  logic                tmr_on;
  logic [PERIOD_W-1:0] tmr_count;
  logic                irq;
  logic [PERIOD_W-1:0] tmr_period;
  bmio_res_t           due_responses[$];
  int                  fails;
  int                  checks;

  function automatic bmio_res_t respond_to(input logic [TYPE_W-1:0] kind,
                                           input logic [BUS_W-1:0]  addr,
                                           input logic [DATA_W-1:0] din);
    bmio_res_t res;
    logic      io;
    res = '0;
    io  = (addr & HOLE_MASK) == HOLE_BASE;
    case (kind)
      REQ_READ: begin
        if (!io) begin
          res.read_data = mem_image[addr[ADDR_BITS_DEF-1:0]];
        end else if (addr == REG_STATUS) begin
          res.read_data[STATUS_TXE_BIT] = txe;
          res.read_data[STATUS_RXF_BIT] = rxf;
        end else if (addr == REG_DATA) begin
          res.read_data = rx_hold;
          rxf = 1'b0;
        end else if (addr == REG_TIMER) begin
          res.read_data[TIMER_ENABLE_BIT] = tmr_on;
          res.read_data[TIMER_CLEAR_BIT]  = irq;
        end
      end
      REQ_WRITE: begin
        if (!io) begin
          mem_image[addr[ADDR_BITS_DEF-1:0]] = din;
        end else if (addr == REG_DATA) begin
          tx_hold = din;
          txe     = 1'b0;
        end else if (addr == REG_TIMER) begin
          tmr_on = din[TIMER_ENABLE_BIT];
          if (din[TIMER_CLEAR_BIT]) begin
            irq = 1'b0;
          end
        end
      end
      REQ_RX: begin
        if (!rxf) begin
          rx_hold           = din;
          rxf               = 1'b1;
          res.host_accepted = 1'b1;
        end
      end
      REQ_TX_TAKEN: begin
        txe = 1'b1;
      end
      REQ_TICK: begin
        if (tmr_on) begin
          if (tmr_count >= tmr_period) begin
            tmr_count = '0;
            irq       = 1'b1;
          end else begin
            tmr_count = tmr_count + 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.irq_active = irq;
    res.tx_pending = !txe;
    res.tx_byte    = tx_hold;
    res.rx_full    = rxf;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    bmio_res_t want;
    if (!rst_n) begin
      foreach (mem_image[i]) mem_image[i] = '0;
      txe        = 1'b1;
      tx_hold    = '0;
      rx_hold    = '0;
      rxf        = 1'b0;
      tmr_on     = 1'b0;
      tmr_count  = '0;
      irq        = 1'b0;
      tmr_period = PERIOD_RESET;
      due_responses.delete();
    end else begin
      if (cfg_we) begin
        tmr_period = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_responses.size() == 0) begin
          $error("response with none outstanding: read_data 0x%0h", out_ch.read_data);
          fails++;
        end else begin
          want = due_responses.pop_front();
          checks++;
          check_field("read_data", want.read_data, out_ch.read_data);
          check_field("irq_active", want.irq_active, out_ch.irq_active);
          check_field("tx_pending", want.tx_pending, out_ch.tx_pending);
          check_field("tx_byte", want.tx_byte, out_ch.tx_byte);
          check_field("rx_full", want.rx_full, out_ch.rx_full);
          check_field("host_accepted", want.host_accepted, out_ch.host_accepted);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        due_responses.push_back(respond_to(in_ch.req_type, in_ch.bus_address, in_ch.data_in));
      end
    end
    fail_count    <= fails;
    open_count    <= due_responses.size();
    checked_count <= checks;
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import bmio_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 305;
  localparam int NUM_PHASES     = 5;

  localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [DATA_W-1:0] TMR_EN        = 8'(1 << TIMER_ENABLE_BIT);
  localparam logic [DATA_W-1:0] TMR_CLR       = 8'(1 << TIMER_CLEAR_BIT);

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_wdata;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int idle_run;
  int sent;
  int fail_count;
  int open_count;
  int checked_count;

  bmio_in_if  in_ch ();
  bmio_out_if out_ch ();

  bus_memory_and_io_responder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bmio_response_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .open_count    (open_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_run <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  task automatic push_req(input logic [TYPE_W-1:0] kind, input logic [BUS_W-1:0] addr,
                          input logic [DATA_W-1:0] din);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.bus_address <= addr;
    in_ch.data_in     <= din;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_period(input logic [PERIOD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [BUS_W-1:0] pick_addr();
    if ($urandom_range(3) == 0) begin
      return BUS_W'(16'hFFC0 + $urandom_range(63));
    end
    return BUS_W'($urandom);
  endfunction

  task automatic random_scenario();
    int                pick;
    logic [BUS_W-1:0]  a;
    logic [DATA_W-1:0] d;
    pick = $urandom_range(99);
    a    = pick_addr();
    d    = DATA_W'($urandom);
    if (pick < 25) begin
      push_req(REQ_WRITE, a, d);
      if ($urandom_range(1)) push_req(REQ_READ, a, DATA_W'($urandom));
      push_req(REQ_READ, pick_addr(), DATA_W'($urandom));
    end else if (pick < 45) begin
      push_req(REQ_RX, BUS_W'($urandom), d);
      if ($urandom_range(1)) push_req(REQ_RX, BUS_W'($urandom), DATA_W'($urandom));
      push_req(REQ_READ, REG_STATUS, DATA_W'($urandom));
      push_req(REQ_READ, REG_DATA, DATA_W'($urandom));
      if ($urandom_range(1)) push_req(REQ_READ, REG_STATUS, DATA_W'($urandom));
    end else if (pick < 60) begin
      push_req(REQ_WRITE, REG_DATA, d);
      push_req(REQ_READ, REG_STATUS, DATA_W'($urandom));
      if ($urandom_range(3) != 0) push_req(REQ_TX_TAKEN, BUS_W'($urandom), DATA_W'($urandom));
      if ($urandom_range(3) == 0) push_req(REQ_TX_TAKEN, BUS_W'($urandom), DATA_W'($urandom));
    end else if (pick < 80) begin
      push_req(REQ_WRITE, REG_TIMER, $urandom_range(3) != 0 ? (d | TMR_EN) : d);
      repeat ($urandom_range(1, 8)) push_req(REQ_TICK, BUS_W'($urandom), DATA_W'($urandom));
      push_req(REQ_READ, REG_TIMER, DATA_W'($urandom));
      if ($urandom_range(1)) push_req(REQ_WRITE, REG_TIMER, TMR_EN | TMR_CLR);
    end else if (pick < 90) begin
      a = HOLE_BASE | BUS_W'($urandom_range(15));
      push_req($urandom_range(1) ? REQ_WRITE : REQ_READ, a, d);
    end else begin
      push_req(TYPE_W'($urandom_range(REQ_READ, REQ_UNUSED_HI)), BUS_W'($urandom), d);
    end
  endtask

  initial begin
    logic [PERIOD_W-1:0] periods   [NUM_PHASES];
    int                  send_pcts [NUM_PHASES];
    int                  recv_pcts [NUM_PHASES];
    int                  phase_start;
    bit                  held;

    periods   = '{16'd0, 16'hFFFF, 16'd3, PERIOD_W'($urandom_range(2, 12)), 16'd1};
    send_pcts = '{0, 55, 0, 28, 0};
    recv_pcts = '{0, 0, 55, 28, 0};

    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= '0;
    in_ch.bus_address <= '0;
    in_ch.data_in     <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    push_req(REQ_READ, 16'h0000, 8'h00);
    push_req(REQ_WRITE, 16'h0000, 8'hFF);
    push_req(REQ_READ, 16'h0000, 8'h00);
    push_req(REQ_WRITE, 16'hFFFF, 8'hA5);
    push_req(REQ_READ, 16'hFFFF, 8'hFF);
    push_req(REQ_WRITE, 16'hFFCF, 8'h5A);
    push_req(REQ_READ, 16'hFFE0, 8'h00);
    push_req(REQ_READ, REG_STATUS, 8'h00);
    push_req(REQ_READ, REG_DATA, 8'h00);
    push_req(REQ_TX_TAKEN, 16'h0000, 8'h00);
    push_req(REQ_RX, 16'h0000, 8'hC3);
    push_req(REQ_RX, 16'hFFFF, 8'h3C);
    push_req(REQ_READ, REG_DATA, 8'h00);
    push_req(REQ_WRITE, REG_DATA, 8'hFF);
    push_req(REQ_READ, REG_STATUS, 8'h00);
    push_req(REQ_TX_TAKEN, 16'h0000, 8'h00);
    push_req(REQ_WRITE, REG_STATUS, 8'hFF);
    push_req(REQ_WRITE, HOLE_BASE | 16'h2, 8'hAA);
    push_req(REQ_READ, HOLE_BASE | 16'h2, 8'h00);
    push_req(REQ_TICK, 16'h0000, 8'h00);
    push_req(REQ_WRITE, REG_TIMER, TMR_EN | TMR_CLR);
    push_req(REQ_TICK, 16'h0000, 8'h00);
    push_req(REQ_READ, REG_TIMER, 8'h00);
    push_req(REQ_UNUSED_LO, 16'hFFD1, 8'hFF);
    push_req(REQ_UNUSED_HI, 16'hFFDD, 8'hFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_period(periods[p]);
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      phase_start    = sent;
      held           = 1'b0;
      while (sent - phase_start < PHASE_ITEMS) begin
        if (recv_pcts[p] != 0 && !held && sent - phase_start >= 60) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        random_scenario();
      end
    end

    settle();
    $display("tb_top: %0d requests over five timer periods from 0 to 65535, %0d responses",
             sent, checked_count);
    $display("tb_top: handshake mixes covered free flow, sender gaps, receiver stalls and both");
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
